/* rtl/cisp_pkg.sv */
// Shared types and constants for the captioned image stream parser.
// No dependencies; the files that use it refer to it by scoped names.
package cisp_pkg;

  // Magic bytes in file order, first byte in the low lane.
  localparam logic [31:0] MAGIC_WORD  = 32'h4646_4943;
  localparam logic [7:0]  CHAR_NL     = 8'h0A;
  localparam logic [7:0]  CHAR_NUL    = 8'h00;
  // Magic plus the header size field itself.
  localparam logic [63:0] HDR_FIXED   = 64'd12;
  // Content size, width and height fields.
  localparam logic [63:0] HDR_FIELDS  = 64'd24;
  localparam logic [63:0] FIELD_BYTES = 64'd8;
  localparam logic [2:0]  FIELD_LAST  = 3'd7;
  localparam logic [2:0]  MAGIC_LAST  = 3'd3;

  typedef enum logic [2:0] {
    KIND_DIMS     = 3'd0,
    KIND_CAP_BYTE = 3'd1,
    KIND_CAP_END  = 3'd2,
    KIND_TAG_BYTE = 3'd3,
    KIND_TAG_END  = 3'd4,
    KIND_PIXEL    = 3'd5,
    KIND_FINISH   = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_CAPTION   = 3'd3,
    ST_TAG       = 3'd4,
    ST_EOF       = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_MAGIC,
    S_HSIZE,
    S_CSIZE,
    S_WIDTH,
    S_HEIGHT,
    S_MUL,
    S_CAPTION,
    S_TAGS,
    S_PIXELS,
    S_TRAIL,
    S_DEAD,
    S_SECOND
  } state_t;

  // One result word as it sits in the output queue.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  text_byte;
    logic [63:0] width_px;
    logic [63:0] height_px;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    status_t     status;
    logic        last_of_run;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic    idx_clr;
    logic    idx_inc;
    logic    fld_load;
    logic    hleft_hsize;
    logic    hleft_sub8;
    logic    hleft_dec;
    logic    content_load;
    logic    content_dec;
    logic    width_load;
    logic    height_load;
    logic    red_load;
    logic    green_load;
    logic    push;
    kind_t   res_kind;
    status_t res_status;
    logic    res_last;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] idx;
    logic       magic_match;
    logic       byte_nl;
    logic       byte_nul;
    logic       hsize_short;
    logic       hleft_zero;
    logic       hleft_one;
    logic       content_zero;
    logic       content_one;
    logic       mul_done;
    logic       size_match;
  } sts_t;

endpackage

/* rtl/cisp_if.sv */
// Valid/ready channel interfaces for the parser's input and result words.
// Uses no package; widths follow the field list of the block.
interface cisp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, data_byte, end_of_file, input ready);
  modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

interface cisp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  text_byte;
  logic [63:0] width_px;
  logic [63:0] height_px;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [2:0]  status;
  logic        last_of_run;

  modport source (output valid, kind, text_byte, width_px, height_px,
                  red, green, blue, status, last_of_run, input ready);
  modport sink   (input valid, kind, text_byte, width_px, height_px,
                  red, green, blue, status, last_of_run, output ready);
endinterface

/* rtl/cisp_mul.sv */
// Shift-add multiplier, 64 x 64 bits modulo 2^64, one multiplier bit per cycle.
// Depends on nothing; used by the datapath for the content size check.
module cisp_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] mcand,
  input  logic [63:0] mplier,
  output logic [63:0] prod,
  output logic        done
);

  localparam logic [5:0] LAST_STEP = 6'd63;

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [63:0] acc_r;
  logic [63:0] mc_r;
  logic [63:0] mp_r;

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == LAST_STEP) busy_r <= 1'b0;
    end
  end

  // accumulate shifted multiplicand where the multiplier bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      mc_r  <= mcand;
      mp_r  <= mplier;
    end else if (busy_r) begin
      if (mp_r[0]) acc_r <= acc_r + mc_r;
      mc_r <= {mc_r[62:0], 1'b0};
      mp_r <= {1'b0, mp_r[63:1]};
    end
  end

  assign prod = acc_r;
  assign done = !busy_r;

endmodule

/* rtl/cisp_outq.sv */
// Two-word result queue that drives the output channel.
// Depends on cisp_pkg (res_t) and cisp_if (cisp_out_if).
module cisp_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cisp_pkg::res_t  din,
  output logic            full,
  cisp_out_if.source      out_q
);

  cisp_pkg::res_t q_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           pop;

  assign pop  = out_q.valid && out_q.ready;
  assign full = (cnt_r == 2'd2);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= din;
  end

  assign out_q.valid       = (cnt_r != 2'd0);
  assign out_q.kind        = q_r[rd_ptr_r].kind;
  assign out_q.text_byte   = q_r[rd_ptr_r].text_byte;
  assign out_q.width_px    = q_r[rd_ptr_r].width_px;
  assign out_q.height_px   = q_r[rd_ptr_r].height_px;
  assign out_q.red         = q_r[rd_ptr_r].red;
  assign out_q.green       = q_r[rd_ptr_r].green;
  assign out_q.blue        = q_r[rd_ptr_r].blue;
  assign out_q.status      = q_r[rd_ptr_r].status;
  assign out_q.last_of_run = q_r[rd_ptr_r].last_of_run;

endmodule

/* rtl/cisp_dp.sv */
// Parser datapath: field assembly, header/content counters, dimensions,
// pixel bytes, size multiplier and result word build. Uses cisp_pkg, cisp_mul.
module cisp_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     in_byte,
  input  cisp_pkg::cmd_t cmd,
  output cisp_pkg::sts_t sts,
  output cisp_pkg::res_t res
);

  logic [2:0]  idx_r;
  logic [63:0] field_r;
  logic [63:0] hleft_r;
  logic [63:0] content_r;
  logic [63:0] width_r;
  logic [63:0] height_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;

  logic [63:0] fld_v;
  logic [63:0] hsize_left;
  logic [63:0] width_x3;
  logic [63:0] prod;
  logic        mul_done;

  // field value as it stands once the current byte lands in the top lane
  assign fld_v      = {in_byte, field_r[55:0]};
  assign hsize_left = fld_v - cisp_pkg::HDR_FIXED;
  assign width_x3   = width_r + {width_r[62:0], 1'b0};

  // byte index within magic, field or pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  // header and body registers
  always_ff @(posedge clk) begin
    if (cmd.fld_load) field_r[{idx_r, 3'b000} +: 8] <= in_byte;

    if (cmd.hleft_hsize) begin
      hleft_r <= hsize_left;
    end else if (cmd.hleft_sub8) begin
      hleft_r <= hleft_r - cisp_pkg::FIELD_BYTES;
    end else if (cmd.hleft_dec) begin
      hleft_r <= hleft_r - 64'd1;
    end

    if (cmd.content_load) begin
      content_r <= fld_v;
    end else if (cmd.content_dec) begin
      content_r <= content_r - 64'd1;
    end

    if (cmd.width_load)  width_r  <= fld_v;
    if (cmd.height_load) height_r <= fld_v;
    if (cmd.red_load)    red_r    <= in_byte;
    if (cmd.green_load)  green_r  <= in_byte;
  end

  // 3 * width * height, started by the byte that completes the height
  cisp_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.height_load),
    .mcand  (width_x3),
    .mplier (fld_v),
    .prod   (prod),
    .done   (mul_done)
  );

  // status back to the controller
  always_comb begin
    sts              = '0;
    sts.idx          = idx_r;
    sts.magic_match  = (in_byte == cisp_pkg::MAGIC_WORD[{idx_r[1:0], 3'b000} +: 8]);
    sts.byte_nl      = (in_byte == cisp_pkg::CHAR_NL);
    sts.byte_nul     = (in_byte == cisp_pkg::CHAR_NUL);
    sts.hsize_short  = (hsize_left < cisp_pkg::HDR_FIELDS);
    sts.hleft_zero   = (hleft_r == 64'd0);
    sts.hleft_one    = (hleft_r == 64'd1);
    sts.content_zero = (content_r == 64'd0);
    sts.content_one  = (content_r == 64'd1);
    sts.mul_done     = mul_done;
    sts.size_match   = (content_r == prod);
  end

  // result word; fields not used by the kind stay zero
  always_comb begin
    res             = '0;
    res.kind        = cmd.res_kind;
    res.status      = cmd.res_status;
    res.last_of_run = cmd.res_last;
    case (cmd.res_kind) inside
      cisp_pkg::KIND_CAP_BYTE, cisp_pkg::KIND_TAG_BYTE: begin
        res.text_byte = in_byte;
      end
      cisp_pkg::KIND_CAP_END: begin
        res.text_byte = cisp_pkg::CHAR_NL;
      end
      cisp_pkg::KIND_DIMS: begin
        res.width_px  = width_r;
        res.height_px = height_r;
      end
      cisp_pkg::KIND_PIXEL: begin
        res.red   = red_r;
        res.green = green_r;
        res.blue  = in_byte;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/cisp_ctrl.sv */
// Parser controller: file phase state machine, result sequencing and
// end-of-file handling. Uses cisp_pkg; drives the datapath by command word.
module cisp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_eof,
  output logic           in_ready,
  input  logic           q_full,
  input  cisp_pkg::sts_t sts,
  output cisp_pkg::cmd_t cmd
);

  cisp_pkg::state_t  state_r, state_nxt;
  cisp_pkg::state_t  ret_r, ret_nxt;
  cisp_pkg::status_t sec_r, sec_nxt;
  logic              eof_r, eof_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cisp_pkg::S_MAGIC;
      ret_r   <= cisp_pkg::S_MAGIC;
      sec_r   <= cisp_pkg::ST_OK;
      eof_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      sec_r   <= sec_nxt;
      eof_r   <= eof_nxt;
    end
  end

  // next state and commands
  always_comb begin
    logic              run;
    logic              defer;
    logic              eof_now;
    logic              have0;
    logic              have1;
    logic              fin;
    cisp_pkg::kind_t   k0;
    cisp_pkg::status_t st0;
    cisp_pkg::status_t st1;
    cisp_pkg::status_t st_e;
    cisp_pkg::state_t  nxt_ph;
    cisp_pkg::state_t  ret;

    cmd            = '0;
    cmd.res_kind   = cisp_pkg::KIND_FINISH;
    cmd.res_status = cisp_pkg::ST_OK;
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    sec_nxt        = sec_r;
    eof_nxt        = eof_r;

    run     = 1'b0;
    defer   = 1'b0;
    eof_now = in_eof;
    have0   = 1'b0;
    have1   = 1'b0;
    fin     = (state_r == cisp_pkg::S_DEAD);
    k0      = cisp_pkg::KIND_FINISH;
    st0     = cisp_pkg::ST_OK;
    st1     = cisp_pkg::ST_OK;
    st_e    = cisp_pkg::ST_OK;
    nxt_ph  = state_r;
    ret     = state_r;

    in_ready = (state_r != cisp_pkg::S_MUL) && (state_r != cisp_pkg::S_SECOND) && !q_full;

    unique case (state_r)
      // size check finished: dims or bad size for the height byte
      cisp_pkg::S_MUL: begin
        if (sts.mul_done && !q_full) begin
          run     = 1'b1;
          eof_now = eof_r;
          have0   = 1'b1;
          if (!sts.size_match) begin
            st0 = cisp_pkg::ST_BAD_SIZE;
            fin = 1'b1;
          end else begin
            k0     = cisp_pkg::KIND_DIMS;
            nxt_ph = cisp_pkg::S_CAPTION;
            if (sts.hleft_zero) begin
              have1 = 1'b1;
              st1   = cisp_pkg::ST_CAPTION;
              fin   = 1'b1;
            end
          end
        end
      end

      // trailing finish word of a two-result byte
      cisp_pkg::S_SECOND: begin
        if (!q_full) begin
          cmd.push       = 1'b1;
          cmd.res_kind   = cisp_pkg::KIND_FINISH;
          cmd.res_status = sec_r;
          cmd.res_last   = 1'b1;
          state_nxt      = ret_r;
        end
      end

      default: begin
        if (in_valid && in_ready) begin
          run = 1'b1;
          case (state_r)
            cisp_pkg::S_MAGIC: begin
              if (!sts.magic_match) begin
                have0 = 1'b1;
                st0   = cisp_pkg::ST_BAD_MAGIC;
                fin   = 1'b1;
              end else if (sts.idx == cisp_pkg::MAGIC_LAST) begin
                cmd.idx_clr = 1'b1;
                nxt_ph      = cisp_pkg::S_HSIZE;
              end else begin
                cmd.idx_inc = 1'b1;
              end
            end

            cisp_pkg::S_HSIZE, cisp_pkg::S_CSIZE, cisp_pkg::S_WIDTH,
            cisp_pkg::S_HEIGHT: begin
              cmd.fld_load = 1'b1;
              if (sts.idx != cisp_pkg::FIELD_LAST) begin
                cmd.idx_inc = 1'b1;
              end else begin
                cmd.idx_clr = 1'b1;
                case (state_r)
                  cisp_pkg::S_HSIZE: begin
                    cmd.hleft_hsize = 1'b1;
                    if (sts.hsize_short) begin
                      have0 = 1'b1;
                      st0   = cisp_pkg::ST_EOF;
                      fin   = 1'b1;
                    end else begin
                      nxt_ph = cisp_pkg::S_CSIZE;
                    end
                  end
                  cisp_pkg::S_CSIZE: begin
                    cmd.content_load = 1'b1;
                    cmd.hleft_sub8   = 1'b1;
                    nxt_ph           = cisp_pkg::S_WIDTH;
                  end
                  cisp_pkg::S_WIDTH: begin
                    cmd.width_load = 1'b1;
                    cmd.hleft_sub8 = 1'b1;
                    nxt_ph         = cisp_pkg::S_HEIGHT;
                  end
                  default: begin
                    // height: start the size multiply and hold the eof mark
                    cmd.height_load = 1'b1;
                    cmd.hleft_sub8  = 1'b1;
                    defer           = 1'b1;
                    eof_nxt         = in_eof;
                    state_nxt       = cisp_pkg::S_MUL;
                  end
                endcase
              end
            end

            cisp_pkg::S_CAPTION: begin
              cmd.hleft_dec = 1'b1;
              have0         = 1'b1;
              if (sts.byte_nl) begin
                k0     = cisp_pkg::KIND_CAP_END;
                nxt_ph = cisp_pkg::S_TAGS;
                if (sts.hleft_one) begin
                  cmd.idx_clr = 1'b1;
                  nxt_ph = sts.content_zero ? cisp_pkg::S_TRAIL : cisp_pkg::S_PIXELS;
                end
              end else begin
                k0 = cisp_pkg::KIND_CAP_BYTE;
                if (sts.hleft_one) begin
                  have1 = 1'b1;
                  st1   = cisp_pkg::ST_CAPTION;
                  fin   = 1'b1;
                end
              end
            end

            cisp_pkg::S_TAGS: begin
              have0 = 1'b1;
              if (sts.byte_nl) begin
                st0 = cisp_pkg::ST_TAG;
                fin = 1'b1;
              end else begin
                cmd.hleft_dec = 1'b1;
                if (sts.byte_nul) begin
                  k0 = cisp_pkg::KIND_TAG_END;
                  if (sts.hleft_one) begin
                    cmd.idx_clr = 1'b1;
                    nxt_ph = sts.content_zero ? cisp_pkg::S_TRAIL : cisp_pkg::S_PIXELS;
                  end
                end else begin
                  k0 = cisp_pkg::KIND_TAG_BYTE;
                  if (sts.hleft_one) begin
                    have1 = 1'b1;
                    st1   = cisp_pkg::ST_TAG;
                    fin   = 1'b1;
                  end
                end
              end
            end

            cisp_pkg::S_PIXELS: begin
              cmd.content_dec = 1'b1;
              case (sts.idx)
                3'd0: begin
                  cmd.red_load = 1'b1;
                  cmd.idx_inc  = 1'b1;
                end
                3'd1: begin
                  cmd.green_load = 1'b1;
                  cmd.idx_inc    = 1'b1;
                end
                default: begin
                  have0       = 1'b1;
                  k0          = cisp_pkg::KIND_PIXEL;
                  cmd.idx_clr = 1'b1;
                end
              endcase
              // a partial pixel at the end of the content is dropped
              if (sts.content_one) begin
                cmd.idx_clr = 1'b1;
                nxt_ph      = cisp_pkg::S_TRAIL;
              end
            end

            default: ;
          endcase
        end
      end
    endcase

    // end-of-file finish, file restart and second-word hand-off
    if (run && !defer) begin
      if (eof_now && !fin) begin
        st_e = (nxt_ph == cisp_pkg::S_TRAIL) ? cisp_pkg::ST_OK : cisp_pkg::ST_EOF;
        if (!have0) begin
          have0 = 1'b1;
          k0    = cisp_pkg::KIND_FINISH;
          st0   = st_e;
        end else begin
          have1 = 1'b1;
          st1   = st_e;
        end
      end
      if (eof_now) begin
        ret         = cisp_pkg::S_MAGIC;
        cmd.idx_clr = 1'b1;
      end else if (fin) begin
        ret = cisp_pkg::S_DEAD;
      end else begin
        ret = nxt_ph;
      end
      cmd.push       = have0;
      cmd.res_kind   = k0;
      cmd.res_status = st0;
      cmd.res_last   = !have1;
      if (have1) begin
        state_nxt = cisp_pkg::S_SECOND;
        ret_nxt   = ret;
        sec_nxt   = st1;
      end else begin
        state_nxt = ret;
      end
    end
  end

endmodule

/* rtl/captioned_image_stream_parser.sv */
// Top level of the captioned image stream parser: controller, datapath and
// result queue. Depends on cisp_pkg, cisp_if, cisp_ctrl, cisp_dp, cisp_outq.
//
//   channel   dir  word                                  handshake
//   in_ch     in   data_byte[7:0], end_of_file           valid/ready
//   out_ch    out  kind, text_byte, width_px/height_px,  valid/ready
//                  red/green/blue, status, last_of_run
//
// One byte per cycle in the common case. The byte that completes the height
// field is accepted first; the input then waits through the 64 steps of the
// shift-add multiply for the 3*width*height check and the push of the result word.
// A byte that causes two result words holds the input while the second word is pushed.
// Otherwise the input stalls only while the two-word result queue is full.
// Reset is synchronous; the parser takes a byte the cycle after reset.
module captioned_image_stream_parser (
  input  logic       clk,
  input  logic       rst_n,
  cisp_in_if.sink    in_ch,
  cisp_out_if.source out_ch
);

  cisp_pkg::cmd_t cmd;
  cisp_pkg::sts_t sts;
  cisp_pkg::res_t res;
  logic           q_full;

  cisp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_eof   (in_ch.end_of_file),
    .in_ready (in_ch.ready),
    .q_full   (q_full),
    .sts      (sts),
    .cmd      (cmd)
  );

  cisp_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_ch.data_byte),
    .cmd     (cmd),
    .sts     (sts),
    .res     (res)
  );

  cisp_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd.push),
    .din   (res),
    .full  (q_full),
    .out_q (out_ch)
  );

endmodule
